// ===== rtl/uwtb_pkg.sv =====
// Package: request and response types, size limits and UTF-8 decode helpers for the trim core.
package uwtb_pkg;

   localparam longint unsigned MAX_BYTES = 65535;
   localparam logic [15:0] LIMIT = 16'((MAX_BYTES < 65535) ? MAX_BYTES : 65535);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [15:0] begin_offset;
      logic [15:0] end_offset;
      logic        too_long;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  len;
      logic [20:0] bits;
   } lead_type;

   function automatic logic ws_member(input logic [20:0] cp);
      return (cp == 21'h20) || (cp >= 21'h09 && cp <= 21'h0D) ||
             (cp >= 21'h1C && cp <= 21'h1F) || (cp == 21'h85) || (cp == 21'hA0) ||
             (cp == 21'h1680) || (cp >= 21'h2000 && cp <= 21'h200A) ||
             (cp == 21'h2028) || (cp == 21'h2029) || (cp == 21'h202F) ||
             (cp == 21'h205F) || (cp == 21'h3000);
   endfunction

   function automatic lead_type lead_info(input logic [7:0] c);
      lead_type r;
      r.len  = 3'd0;
      r.bits = '0;
      if (c[7] == 1'b0) begin
         r.len  = 3'd1;
         r.bits = {13'd0, c};
      end else if ((c & 8'hE0) == 8'hC0) begin
         r.len  = 3'd2;
         r.bits = {16'd0, c[4:0]};
      end else if ((c & 8'hF0) == 8'hE0) begin
         r.len  = 3'd3;
         r.bits = {17'd0, c[3:0]};
      end else if ((c & 8'hF8) == 8'hF0) begin
         r.len  = 3'd4;
         r.bits = {18'd0, c[2:0]};
      end
      return r;
   endfunction

   function automatic logic unit_is_ws(input logic [2:0] exp_len, input logic [2:0] seen_len,
                                       input logic [20:0] cp);
      return (exp_len != 3'd0) && (seen_len == exp_len) && ws_member(cp);
   endfunction

endpackage

// ===== rtl/utf8_whitespace_trim_bounds_core.sv =====
// Top level: byte-serial UTF-8 whitespace trim, reporting kept begin and end offsets.
//
//   channel  ports                          direction  carries
//   req      req_valid, req_stall, req_data in         one string byte and last mark
//   rsp      rsp_valid, rsp_stall, rsp_data out        trim bounds and too_long flag
//
// One byte is taken every cycle while req_stall is low; the decode state updates at the accepting edge.
// The bounds of a string appear on rsp in the cycle after its last byte is accepted.
// The only stall path: req_stall is high while a response is held and rsp_stall is high.
// Synchronous reset clears all decode state and the response valid.
module utf8_whitespace_trim_bounds_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  uwtb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output uwtb_pkg::rsp_type rsp_data
);
   import uwtb_pkg::*;

   logic [15:0] byte_position_ff, byte_position_in;
   logic        begin_found_ff, begin_found_in;
   logic [15:0] begin_position_ff, begin_position_in;
   logic [15:0] lead_start_ff, lead_start_in;
   logic [20:0] lead_code_point_ff, lead_code_point_in;
   logic [1:0]  lead_bytes_left_ff, lead_bytes_left_in;
   logic [2:0]  unit_expected_len_ff, unit_expected_len_in;
   logic [2:0]  unit_seen_len_ff, unit_seen_len_in;
   logic [20:0] unit_code_point_ff, unit_code_point_in;
   logic [15:0] kept_end_ff, kept_end_in;
   logic        overflowed_ff, overflowed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic [7:0]  c;
   logic        cont;
   logic [15:0] idx, nxt;
   lead_type    lead_li, unit_li;
   logic [15:0] kept_final, b_off;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign c    = req_data.data_byte;
   assign cont = (c & 8'hC0) == 8'h80;
   assign idx  = byte_position_ff;
   assign nxt  = (byte_position_ff == LIMIT) ? LIMIT : byte_position_ff + 16'd1;

   always_comb begin
      overflowed_in      = overflowed_ff || (byte_position_ff == LIMIT);
      byte_position_in   = nxt;
      begin_found_in     = begin_found_ff;
      begin_position_in  = begin_position_ff;
      lead_start_in      = lead_start_ff;
      lead_code_point_in = lead_code_point_ff;
      lead_bytes_left_in = lead_bytes_left_ff;
      lead_li            = lead_info(c);
      unit_li            = lead_li;

      if (!begin_found_ff) begin
         if (lead_bytes_left_ff == 2'd0) begin
            lead_start_in = idx;
            if (lead_li.len == 3'd0 || (lead_li.len == 3'd1 && !ws_member(lead_li.bits))) begin
               begin_found_in    = 1'b1;
               begin_position_in = idx;
            end else if (lead_li.len > 3'd1) begin
               lead_code_point_in = lead_li.bits;
               lead_bytes_left_in = 2'(lead_li.len - 3'd1);
            end
         end else if (!cont) begin
            begin_found_in    = 1'b1;
            begin_position_in = lead_start_ff;
         end else begin
            lead_code_point_in = {lead_code_point_ff[14:0], c[5:0]};
            lead_bytes_left_in = lead_bytes_left_ff - 2'd1;
            if (lead_bytes_left_in == 2'd0 && !ws_member(lead_code_point_in)) begin
               begin_found_in    = 1'b1;
               begin_position_in = lead_start_ff;
            end
         end
      end

      unit_expected_len_in = unit_expected_len_ff;
      unit_seen_len_in     = unit_seen_len_ff;
      unit_code_point_in   = unit_code_point_ff;
      kept_end_in          = kept_end_ff;
      if (cont && unit_seen_len_ff != 3'd0) begin
         if (unit_seen_len_ff < unit_expected_len_ff) begin
            unit_code_point_in = {unit_code_point_ff[14:0], c[5:0]};
         end
         if (unit_seen_len_ff < 3'd7) begin
            unit_seen_len_in = unit_seen_len_ff + 3'd1;
         end
      end else begin
         if (unit_seen_len_ff != 3'd0 &&
             !unit_is_ws(unit_expected_len_ff, unit_seen_len_ff, unit_code_point_ff)) begin
            kept_end_in = idx;
         end
         unit_expected_len_in = unit_li.len;
         unit_code_point_in   = unit_li.bits;
         unit_seen_len_in     = 3'd1;
      end

      kept_final = unit_is_ws(unit_expected_len_in, unit_seen_len_in, unit_code_point_in) ?
                   kept_end_in : nxt;
      if (begin_found_in) begin
         b_off = begin_position_in;
      end else begin
         b_off = (lead_bytes_left_in != 2'd0) ? lead_start_in : nxt;
      end
      rsp_data_in.begin_offset = b_off;
      rsp_data_in.end_offset   = (kept_final > b_off) ? kept_final : b_off;
      rsp_data_in.too_long     = overflowed_in;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept && req_data.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff     <= '0;
         begin_found_ff       <= 1'b0;
         begin_position_ff    <= '0;
         lead_start_ff        <= '0;
         lead_code_point_ff   <= '0;
         lead_bytes_left_ff   <= '0;
         unit_expected_len_ff <= '0;
         unit_seen_len_ff     <= '0;
         unit_code_point_ff   <= '0;
         kept_end_ff          <= '0;
         overflowed_ff        <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            if (req_data.last) begin
               byte_position_ff     <= '0;
               begin_found_ff       <= 1'b0;
               begin_position_ff    <= '0;
               lead_start_ff        <= '0;
               lead_code_point_ff   <= '0;
               lead_bytes_left_ff   <= '0;
               unit_expected_len_ff <= '0;
               unit_seen_len_ff     <= '0;
               unit_code_point_ff   <= '0;
               kept_end_ff          <= '0;
               overflowed_ff        <= 1'b0;
            end else begin
               byte_position_ff     <= byte_position_in;
               begin_found_ff       <= begin_found_in;
               begin_position_ff    <= begin_position_in;
               lead_start_ff        <= lead_start_in;
               lead_code_point_ff   <= lead_code_point_in;
               lead_bytes_left_ff   <= lead_bytes_left_in;
               unit_expected_len_ff <= unit_expected_len_in;
               unit_seen_len_ff     <= unit_seen_len_in;
               unit_code_point_ff   <= unit_code_point_in;
               kept_end_ff          <= kept_end_in;
               overflowed_ff        <= overflowed_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_end_not_below_begin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.end_offset >= rsp_data_ff.begin_offset))
      else $error("end offset below begin offset");

   a_state_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last) |=> (byte_position_ff == 16'd0 && unit_seen_len_ff == 3'd0))
      else $error("decode state not cleared after last byte");

   a_unit_open_once_started: assert property (@(posedge clock) disable iff (reset)
      (byte_position_ff != 16'd0) |-> (unit_seen_len_ff != 3'd0))
      else $error("no open unit after bytes were taken");

   a_stall_only_on_held_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled with no response held");

   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last) |=> rsp_valid_ff)
      else $error("no response after last byte");
`endif

endmodule
